// ===== hdl/cassette_half_cycle_byte_decoder_unit_macros.svh =====
// Assertion macros shared by the cassette decoder RTL.
`ifndef CASSETTE_HALF_CYCLE_BYTE_DECODER_UNIT_MACROS_SVH
`define CASSETTE_HALF_CYCLE_BYTE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHCBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/chcbd_pkg.sv =====
package chcbd_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int SYNC_THR_W = 7;
  localparam int BIT_THR_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD  = 1'd1;

  // Reset values.
  localparam logic [SYNC_THR_W-1:0] SYNC_THR_RESET = 7'd23;
  localparam logic [BIT_THR_W-1:0]  BIT_THR_RESET  = 8'd30;
  localparam logic [BYTE_W-1:0]     CHECK_SEED     = 8'hFF;

endpackage

// ===== hdl/cassette_half_cycle_byte_decoder_unit.sv =====
// Cassette half-cycle byte decoder. Each accepted item is one signed audio sample (mode 0) or a
// restart request (mode 1); the block measures the run between sign changes, hunts for the long
// sync tone, then turns each pair of half-cycles into one bit and delivers a byte, its running
// XOR check and a record-start flag as one result item. One item is taken in every cycle that
// in_stall is low, and its result, if any, is registered for the output port; the rate is set
// by a single pass through the half-cycle counter, the phase logic and the bit shifter, all
// between the accepting edge and the result register. An output register backed by a one-entry
// skid register decouples the two sides, so in_stall rises only when a result arrives while
// out_stall holds a previous one. The user writes the thresholds through the plain configuration
// port only while the block is idle, which it does not enforce; they apply from the next sample.
`include "cassette_half_cycle_byte_decoder_unit_macros.svh"

module cassette_half_cycle_byte_decoder_unit #(
  parameter int MAX_HALF_CYCLE = 80,
  parameter int SYNC_RUN       = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [chcbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chcbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic signed [chcbd_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [chcbd_pkg::BYTE_W-1:0]         byte_value,
  output logic [chcbd_pkg::BYTE_W-1:0]         check_value,
  output logic                                 record_start
);
  import chcbd_pkg::*;

  // The run counter must be able to hold the saturation value itself.
  localparam int RUN_W = $clog2(MAX_HALF_CYCLE + 1);
  localparam int CNT_W = $clog2(SYNC_RUN + 1);
  localparam int CMP_W = (RUN_W > SYNC_THR_W) ? RUN_W : SYNC_THR_W;
  localparam int SUM_W = (RUN_W + 1 > BIT_THR_W) ? RUN_W + 1 : BIT_THR_W;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_WAIT_SHORT,
    PH_SKIP,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] check_value;
    logic              record_start;
  } result_t;

  // Configuration.
  logic [SYNC_THR_W-1:0] sync_threshold;
  logic [BIT_THR_W-1:0]  bit_threshold;

  // Half-cycle measurement.
  logic             prev_negative, prev_negative_next;
  logic [RUN_W-1:0] run_length, run_length_next;

  // Decoder state.
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  long_count, long_count_next;
  logic [RUN_W-1:0]  first_half, first_half_next;
  logic              half_select, half_select_next;
  logic [2:0]        bit_count, bit_count_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [BYTE_W-1:0] running_check, running_check_next;
  logic              start_pending, start_pending_next;

  // Output register and skid register.
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  // Result of the item being accepted this cycle.
  result_t new_result;
  logic    new_valid;

  logic accept;
  logic take;
  logic neg;
  logic sign_change;
  logic keep_length;
  logic bit_one;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  assign byte_value   = out_reg.byte_value;
  assign check_value  = out_reg.check_value;
  assign record_start = out_reg.record_start;

  assign neg         = sample[SAMPLE_W-1];
  assign sign_change = (neg != prev_negative);
  assign keep_length = sign_change && (run_length < RUN_W'(MAX_HALF_CYCLE));
  assign bit_one     = (SUM_W'(first_half) + SUM_W'(run_length)) > SUM_W'(bit_threshold);

  always_comb begin
    prev_negative_next = prev_negative;
    run_length_next    = run_length;
    phase_next         = phase;
    long_count_next    = long_count;
    first_half_next    = first_half;
    half_select_next   = half_select;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    running_check_next = running_check;
    start_pending_next = start_pending;
    new_valid          = 1'b0;
    new_result         = '{byte_value: shift_byte, check_value: running_check,
                           record_start: start_pending};

    if (mode) begin
      // A restart leaves the sign tracking alone and sends the decoder back to the hunt.
      phase_next         = PH_HUNT;
      long_count_next    = '0;
      half_select_next   = 1'b0;
      bit_count_next     = '0;
      shift_byte_next    = '0;
      start_pending_next = 1'b0;
    end else begin
      if (sign_change) begin
        prev_negative_next = neg;
        // The new run has already seen this sample.
        run_length_next    = RUN_W'(1);
      end else if (run_length < RUN_W'(MAX_HALF_CYCLE)) begin
        run_length_next = run_length + RUN_W'(1);
      end

      if (keep_length) begin
        case (phase)
          PH_HUNT: begin
            if (CMP_W'(run_length) > CMP_W'(sync_threshold)) begin
              if (long_count >= CNT_W'(SYNC_RUN)) begin
                long_count_next = '0;
                phase_next      = PH_WAIT_SHORT;
              end else begin
                long_count_next = long_count + CNT_W'(1);
              end
            end else begin
              long_count_next = '0;
            end
          end
          PH_WAIT_SHORT: begin
            if (CMP_W'(run_length) < CMP_W'(sync_threshold)) begin
              phase_next = PH_SKIP;
            end
          end
          PH_SKIP: begin
            phase_next         = PH_DATA;
            running_check_next = CHECK_SEED;
            start_pending_next = 1'b1;
            bit_count_next     = '0;
            half_select_next   = 1'b0;
            shift_byte_next    = '0;
          end
          default: begin
            if (!half_select) begin
              first_half_next  = run_length;
              half_select_next = 1'b1;
            end else begin
              half_select_next = 1'b0;
              shift_byte_next  = {shift_byte[BYTE_W-2:0], bit_one};
              if (bit_count != 3'd7) begin
                bit_count_next = bit_count + 3'd1;
              end else begin
                // Eighth bit: the byte is complete and leaves with its check.
                bit_count_next          = '0;
                running_check_next      = running_check ^ shift_byte_next;
                start_pending_next      = 1'b0;
                new_valid               = 1'b1;
                new_result.byte_value   = shift_byte_next;
                new_result.check_value  = running_check_next;
                new_result.record_start = start_pending;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_threshold <= SYNC_THR_RESET;
      bit_threshold  <= BIT_THR_RESET;
      prev_negative  <= 1'b1;
      run_length     <= '0;
      phase          <= PH_HUNT;
      long_count     <= '0;
      first_half     <= '0;
      half_select    <= 1'b0;
      bit_count      <= '0;
      shift_byte     <= '0;
      running_check  <= CHECK_SEED;
      start_pending  <= 1'b0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_SYNC_THRESHOLD: sync_threshold <= cfg_data[SYNC_THR_W-1:0];
          CFG_BIT_THRESHOLD:  bit_threshold  <= cfg_data[BIT_THR_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        prev_negative <= prev_negative_next;
        run_length    <= run_length_next;
        phase         <= phase_next;
        long_count    <= long_count_next;
        first_half    <= first_half_next;
        half_select   <= half_select_next;
        bit_count     <= bit_count_next;
        shift_byte    <= shift_byte_next;
        running_check <= running_check_next;
        start_pending <= start_pending_next;
      end

      // While the skid register is full no item is accepted, so it only has to drain.
      if (skid_valid) begin
        if (take) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (!out_valid || take) begin
        out_valid <= accept && new_valid;
        out_reg   <= new_result;
      end else if (accept && new_valid) begin
        skid_reg   <= new_result;
        skid_valid <= 1'b1;
      end
    end
  end

  `CHCBD_ASSERT_NOW(a_skid_implies_out, skid_valid, out_valid, "skid holds an item but output register is empty")
  `CHCBD_ASSERT_NEXT(a_held_result_to_skid, accept && new_valid && out_valid && out_stall, skid_valid, "result lost while output was stalled")
  `CHCBD_ASSERT_NEXT(a_restart_clears, accept && mode, (phase == PH_HUNT) && !start_pending && !half_select, "restart did not return decoder to the hunt")
  `CHCBD_ASSERT_NOW(a_run_saturates, 1'b1, run_length <= RUN_W'(MAX_HALF_CYCLE), "run length above saturation value")

endmodule

// ===== bench/tb_cassette_half_cycle_byte_decoder_unit.sv =====
module tb_cassette_half_cycle_byte_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import chcbd_pkg::*;

  // Limits of the half-cycle measurement and of the sync hunt, as built into the block.
  localparam int MAX_RUN    = 80;
  localparam int SYNC_COUNT = 16;

  // Values of the mode field of an input item.
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // The long receiver hold-off, the idle-cycle watchdog and the pause that lets the
  // block settle after its last byte before a register write or the end of the run.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int REPORT_LINES   = 40;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_WAIT_SHORT,
    PH_SKIP,
    PH_DATA
  } decode_phase_t;

  // One decoded byte as the output item carries it.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic [BYTE_W-1:0] check_val;
    logic              start_flag;
  } decoded_byte_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  mode;
  logic signed [SAMPLE_W-1:0] sample;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     byte_value;
  logic [BYTE_W-1:0]     check_value;
  logic                  record_start;

  cassette_half_cycle_byte_decoder_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_value   (byte_value),
    .check_value  (check_value),
    .record_start (record_start)
  );

  // Predictor state. It mirrors the block's registers and is advanced once for every
  // accepted input item, at the edge that accepts it.
  logic [SYNC_THR_W-1:0] sync_thr;
  logic [BIT_THR_W-1:0]  bit_thr;
  logic                  last_negative;
  logic [6:0]            run_len;
  decode_phase_t         dec_phase;
  logic [4:0]            long_cnt;
  logic [6:0]            first_len;
  logic                  second_half;
  logic [2:0]            bits_done;
  logic [BYTE_W-1:0]     shifter;
  logic [BYTE_W-1:0]     check_acc;
  logic                  start_due;

  decoded_byte_t pending_bytes[$];

  // Stimulus state: the sign of the tone being generated and the idling rates.
  logic        tone_negative = 1'b1;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          hold_request  = 0;
  int          hold_left     = 0;

  int items_sent    = 0;
  int bytes_checked = 0;
  int fail_count    = 0;
  int idle_cycles   = 0;

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LINES) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // A restart item sends the decoder back to the hunt; the half-cycle measurement
  // carries on regardless.
  function automatic void clear_decoder();
    dec_phase   = PH_HUNT;
    long_cnt    = '0;
    second_half = 1'b0;
    bits_done   = '0;
    shifter     = '0;
    start_due   = 1'b0;
  endfunction

  // One kept half-cycle length drives the hunt, the wait for the short cycle, the skipped
  // cycle and then the pairing of half-cycles into bits.
  function automatic void take_half_cycle(input logic [6:0] len);
    case (dec_phase)
      PH_HUNT: begin
        if (len > sync_thr) begin
          if (long_cnt >= SYNC_COUNT) begin
            long_cnt  = '0;
            dec_phase = PH_WAIT_SHORT;
          end else begin
            long_cnt++;
          end
        end else begin
          long_cnt = '0;
        end
      end
      PH_WAIT_SHORT: begin
        if (len < sync_thr) dec_phase = PH_SKIP;
      end
      PH_SKIP: begin
        dec_phase   = PH_DATA;
        check_acc   = CHECK_SEED;
        start_due   = 1'b1;
        bits_done   = '0;
        second_half = 1'b0;
        shifter     = '0;
      end
      default: begin
        if (!second_half) begin
          first_len   = len;
          second_half = 1'b1;
        end else begin
          second_half = 1'b0;
          shifter = {shifter[BYTE_W-2:0], (int'(first_len) + int'(len)) > int'(bit_thr)};
          if (bits_done != 3'd7) begin
            bits_done++;
          end else begin
            bits_done = '0;
            check_acc = check_acc ^ shifter;
            pending_bytes.push_back('{byte_val: shifter, check_val: check_acc,
                                      start_flag: start_due});
            start_due = 1'b0;
          end
        end
      end
    endcase
  endfunction

  // A sign change closes the running half-cycle; runs that reached the saturation
  // length are dropped rather than decoded.
  function automatic void decode_item(input logic item_mode, input logic [SAMPLE_W-1:0] s);
    if (item_mode == MODE_RESTART) begin
      clear_decoder();
    end else begin
      if (s[SAMPLE_W-1] != last_negative) begin
        last_negative = s[SAMPLE_W-1];
        if (run_len < MAX_RUN) take_half_cycle(run_len);
        run_len = '0;
      end
      if (run_len < MAX_RUN) run_len++;
    end
  endfunction

  // Prediction, checking and the watchdog share one process, so that an item accepted
  // at an edge is predicted before any result at that edge is compared.
  always @(posedge clk) begin
    decoded_byte_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && !in_stall) decode_item(mode, sample);
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h check %02h start %0b",
                                    byte_value, check_value, record_start));
        end else begin
          want = pending_bytes.pop_front();
          bytes_checked++;
          if (byte_value !== want.byte_val)
            report_mismatch($sformatf("byte_value %02h, predicted %02h",
                                      byte_value, want.byte_val));
          if (check_value !== want.check_val)
            report_mismatch($sformatf("check_value %02h, predicted %02h",
                                      check_value, want.check_val));
          if (record_start !== want.start_flag)
            report_mismatch($sformatf("record_start %0b, predicted %0b",
                                      record_start, want.start_flag));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // The receiver stalls at random, or for a long stretch when a hold-off is requested.
  // Requests are posted at the rising edge and picked up here at the falling one.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one item from a falling edge and returns at the falling edge after it was
  // taken. Valid stays high on return so that back-to-back items leave no gap; anything
  // other than a further item must lower it first.
  task automatic send_item(input logic item_mode, input logic [SAMPLE_W-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat (1 + $urandom_range(3)) @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = item_mode;
    sample   = s;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_restart();
    send_item(MODE_RESTART, SAMPLE_W'($urandom));
  endtask

  // One half-cycle of the tone: len samples of the opposite sign to the last run, with
  // the extreme sample values mixed in among random ones.
  task automatic send_run(input int len);
    logic [SAMPLE_W-1:0] s;
    tone_negative = !tone_negative;
    repeat (len) begin
      case ($urandom_range(7))
        0:       s = tone_negative ? 16'h8000 : 16'h7FFF;
        1:       s = tone_negative ? 16'hFFFF : 16'h0000;
        default: s = {tone_negative, 15'($urandom)};
      endcase
      send_item(MODE_SAMPLE, s);
    end
  endtask

  // A half-cycle length just above the current sync threshold.
  function automatic int long_len();
    if (sync_thr >= 78) return 79;
    return int'(sync_thr) + 1 + $urandom_range(1);
  endfunction

  // Leader tone, then the short cycle that ends it and the cycle that is skipped.
  task automatic send_leader(input int n_long);
    int short_len;
    short_len = (sync_thr < 2) ? 1 :
                1 + $urandom_range((int'(sync_thr) - 2 > 2) ? 2 : int'(sync_thr) - 2);
    repeat (n_long) send_run(long_len());
    send_run(short_len);
    send_run(1 + $urandom_range(2));
  endtask

  // Each bit is two half-cycles whose sum sits just above the bit threshold for a one
  // and at or just below it for a zero, so that the comparison is pressed at its edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int sum;
    int a;
    int c;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (b[i]) sum = int'(bit_thr) + 1 + $urandom_range(2);
      else      sum = int'(bit_thr) - $urandom_range(2);
      if (sum < 2)   sum = 2;
      if (sum > 158) sum = 158;
      a = sum / 2;
      c = sum - a;
      if (a > 1 && c < 79 && $urandom_range(1)) begin
        a--;
        c++;
      end
      send_run(a);
      send_run(c);
    end
  endtask

  // Waits until every predicted byte has been delivered and the block has settled.
  task automatic wait_idle();
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Registers are only written with the block idle; the predictor's copy changes at
  // the same time.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    in_valid = 1'b0;
    wait_idle();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == CFG_SYNC_THRESHOLD) sync_thr = val[SYNC_THR_W-1:0];
    else                           bit_thr  = val[BIT_THR_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_thresholds(input int sync_value, input int bit_value);
    write_register(CFG_SYNC_THRESHOLD, CFG_DATA_W'(sync_value));
    write_register(CFG_BIT_THRESHOLD, CFG_DATA_W'(bit_value));
  endtask

  // Straight after reset, with the thresholds at their reset values. The very first
  // sample is non-negative, which the block treats as a sign change and so measures a
  // half-cycle of length zero. The leader has exactly the minimum number of long cycles.
  task automatic test_first_sample_and_default_record();
    send_leader(SYNC_COUNT + 1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_run(1);
  endtask

  // One long cycle too few must not sync; the minimum and a much longer leader must,
  // the latter keeping the decoder in the wait for the short cycle through further long cycles.
  task automatic test_sync_run_count();
    set_thresholds(2, 4);
    send_restart();
    send_leader(SYNC_COUNT);
    send_restart();
    send_leader(SYNC_COUNT + 1);
    send_byte(8'h81);
    send_restart();
    send_leader(30);
    send_byte(8'h7E);
    send_run(1);
  endtask

  // Runs that saturate the counter are dropped both inside the leader and between the
  // two halves of a bit, while a run one sample shorter is still measured.
  task automatic test_long_run_dropped();
    send_restart();
    repeat (8) send_run(long_len());
    send_run(MAX_RUN + 5);
    send_leader(9);
    send_run(MAX_RUN - 1);
    send_run(MAX_RUN);
    send_run(100);
    send_run(1);
    send_byte(8'hC3);
    send_run(1);
  endtask

  // Restart items in the middle of a byte, back to back, while waiting for the short
  // cycle and in the middle of a run; their samples, extremes included, are ignored.
  task automatic test_restart();
    send_restart();
    send_leader(SYNC_COUNT + 1);
    repeat (6) send_run(1 + $urandom_range(3));
    send_item(MODE_RESTART, 16'h8000);
    send_leader(SYNC_COUNT + 1);
    send_byte(8'h96);
    send_item(MODE_RESTART, 16'h7FFF);
    send_item(MODE_RESTART, 16'h0000);
    repeat (SYNC_COUNT + 2) send_run(long_len());
    send_item(MODE_RESTART, 16'hFFFF);
    send_leader(SYNC_COUNT + 1);
    send_byte(8'h3C);
    send_item(MODE_SAMPLE, {tone_negative, 15'h1234});
    send_restart();
    send_item(MODE_SAMPLE, {tone_negative, 15'h0000});
    send_run(1);
  endtask

  // Threshold extremes: every bit a one, every bit a zero, a sync threshold no kept
  // length can exceed, and one that no length can fall below.
  task automatic test_threshold_extremes();
    set_thresholds(2, 0);
    send_restart();
    send_leader(SYNC_COUNT + 1);
    send_byte(8'($urandom));
    send_run(1);
    set_thresholds(2, 255);
    send_restart();
    send_leader(SYNC_COUNT + 1);
    send_byte(8'hFF);
    send_run(1);
    set_thresholds(127, 30);
    send_restart();
    repeat (4) send_run(MAX_RUN - 1);
    send_run(1);
    set_thresholds(0, 30);
    send_restart();
    repeat (SYNC_COUNT + 2) send_run(1);
    repeat (4) send_run(1 + $urandom_range(3));
    send_restart();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items,
  // so the output register and its skid entry fill and the block stalls its input.
  task automatic test_output_backpressure();
    int unsigned saved_pct;
    set_thresholds(2, 4);
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    send_restart();
    send_leader(SYNC_COUNT + 1);
    repeat (12) send_byte(8'($urandom));
    send_run(1);
    send_idle_pct = saved_pct;
  endtask

  // Mostly well-formed records with random bytes, mixed with noise, saturating runs,
  // broken leaders and stray restart items.
  task automatic test_random_records(input int unsigned s_pct, input int unsigned r_pct);
    int items_at;
    int bytes_at;
    int pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    set_thresholds(2 + $urandom_range(5), 2 + $urandom_range(7));
    items_at = items_sent;
    bytes_at = bytes_checked;
    while (items_sent - items_at < 350 || bytes_checked - bytes_at < 12) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_restart();
        send_leader(SYNC_COUNT + 1 + $urandom_range(3));
        repeat (1 + $urandom_range(4)) send_byte(8'($urandom));
        if ($urandom_range(3) == 0) send_restart();
      end else if (pick < 80) begin
        repeat (1 + $urandom_range(5))
          send_run(($urandom_range(9) == 0) ? MAX_RUN + $urandom_range(10)
                                            : 1 + $urandom_range(12));
      end else if (pick < 92) begin
        send_restart();
        repeat (3 + $urandom_range(14)) send_run(long_len());
        if ($urandom_range(1)) send_restart();
        else                   send_run(1);
      end else begin
        send_restart();
      end
    end
    send_run(1);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_SYNC_THRESHOLD;
    cfg_data      = '0;
    in_valid      = 1'b0;
    mode          = MODE_SAMPLE;
    sample        = '0;
    send_idle_pct = 26;
    recv_idle_pct = 49;

    // Predictor at its reset state.
    sync_thr      = SYNC_THR_RESET;
    bit_thr       = BIT_THR_RESET;
    last_negative = 1'b1;
    run_len       = '0;
    first_len     = '0;
    check_acc     = CHECK_SEED;
    clear_decoder();

    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_first_sample_and_default_record();
    test_sync_run_count();
    test_long_run_dropped();
    test_restart();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_records(26, 49);
    test_random_records(49, 26);
    test_random_records(0, 0);

    in_valid = 1'b0;
    wait_idle();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/chcbd_pkg.sv
hdl/cassette_half_cycle_byte_decoder_unit.sv
bench/tb_cassette_half_cycle_byte_decoder_unit.sv
